/* rtl/spgpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo pan / gain / peak meter package
// Shared constants, configuration register map, controller states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package spgpm_pkg;

  // Default sizes for the top-level parameters.
  localparam int SampleWidthDef   = 24;
  localparam int PanTableDepthDef = 256;

  // Configuration port geometry.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] VolumeReset = 16'd32768;
  localparam logic [15:0] DecayReset  = 16'd62259;

  // Odd polynomial for sin(pi/2 * x), coefficients in Q30.
  localparam logic [63:0] SinA1 = 64'd1686629713;
  localparam logic [63:0] SinA3 = 64'd693598671;
  localparam logic [63:0] SinA5 = 64'd85569306;
  localparam logic [63:0] SinA7 = 64'd5026995;
  localparam logic [63:0] SinA9 = 64'd172270;

  // Register indexes on the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    RegVolume      = 3'd0,
    RegPan         = 3'd1,
    RegMute        = 3'd2,
    RegSolo        = 3'd3,
    RegOtherSoloed = 3'd4,
    RegDecay       = 3'd5,
    RegMono        = 3'd6
  } cfg_reg_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] volume_gain;
    logic [15:0] pan_position;
    logic        mute_enable;
    logic        solo_enable;
    logic        other_soloed;
    logic [15:0] decay_factor;
    logic        mono_mode;
  } cfg_t;

  // Controller states, one per datapath step.
  typedef enum logic [2:0] {
    StIdle,
    StIndex,
    StGain,
    StScale,
    StSat,
    StMeter
  } ctrl_state_e;

  // Step enables from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_idx;
    logic load_gain;
    logic load_prod;
    logic load_sat;
    logic commit;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* rtl/stereo_pan_gain_peak_meter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each sample pair passes in turn through the five datapath steps (pan index,
// gain multiply, sample multiply, saturate, meter update); the meter step waits
// while the output register is full, and a new pair is taken only after commit.
// A new input is taken while the previous result still waits to be read.
// Reset clears the controller, the meters and peaks, and loads the register
// defaults; the pan table is constant and needs no fill time.
// ----------------------------------------------------------------------------
// Stereo pan, gain and peak meter channel strip
// Applies volume and constant-power pan to a stereo pair, with mute, solo
// and mono handling, and reports decaying block peak levels per channel.
// ----------------------------------------------------------------------------
module stereo_pan_gain_peak_meter_core #(
  parameter int SAMPLE_WIDTH    = spgpm_pkg::SampleWidthDef,
  parameter int PAN_TABLE_DEPTH = spgpm_pkg::PanTableDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spgpm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [spgpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_left_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_right_i,
  input  wire logic                           block_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right_o,
  output logic [SAMPLE_WIDTH-2:0]             meter_left_o,
  output logic [SAMPLE_WIDTH-2:0]             meter_right_o
);
  import spgpm_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // Configuration registers.
  spgpm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Step sequencer.
  spgpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and meter state.
  spgpm_dp #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PAN_TABLE_DEPTH (PAN_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .block_end_i    (block_end_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .meter_left_o   (meter_left_o),
    .meter_right_o  (meter_right_o)
  );

`ifndef ASSERT_OFF
  // An accepted transaction keeps the input closed for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while an item is in progress");

  // A silenced channel delivers zero samples.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cfg.mute_enable || (cfg.other_soloed && !cfg.solo_enable)))
    |-> (out_left_o == '0 && out_right_o == '0))
    else $error("silenced channel produced a nonzero sample");

  // In mono mode the right output is zero and both meters agree.
  a_mono_meters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cfg.mono_mode)
    |-> (out_right_o == '0 && meter_right_o == meter_left_o))
    else $error("mono result has a right sample or split meters");
`endif

endmodule
`default_nettype wire

/* rtl/spgpm_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the channel strip settings, written through a plain write port.
// Writes to an index outside the register map are dropped.
// ----------------------------------------------------------------------------
module spgpm_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spgpm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [spgpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output spgpm_pkg::cfg_t                    cfg_o
);
  import spgpm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegVolume:      cfg_d.volume_gain  = cfg_wdata_i;
        RegPan:         cfg_d.pan_position = cfg_wdata_i;
        RegMute:        cfg_d.mute_enable  = cfg_wdata_i[0];
        RegSolo:        cfg_d.solo_enable  = cfg_wdata_i[0];
        RegOtherSoloed: cfg_d.other_soloed = cfg_wdata_i[0];
        RegDecay:       cfg_d.decay_factor = cfg_wdata_i;
        RegMono:        cfg_d.mono_mode    = cfg_wdata_i[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_gain  <= VolumeReset;
      cfg_q.pan_position <= '0;
      cfg_q.mute_enable  <= 1'b0;
      cfg_q.solo_enable  <= 1'b0;
      cfg_q.other_soloed <= 1'b0;
      cfg_q.decay_factor <= DecayReset;
      cfg_q.mono_mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/spgpm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencing controller
// Steps one sample pair through index, gain, scale, saturate and meter
// steps, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module spgpm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output spgpm_pkg::dp_cmd_t  cmd_o
);
  import spgpm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Next state and step commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StIndex;
        end
      end
      StIndex: begin
        cmd_o.load_idx = 1'b1;
        state_d        = StGain;
      end
      StGain: begin
        cmd_o.load_gain = 1'b1;
        state_d         = StScale;
      end
      StScale: begin
        cmd_o.load_prod = 1'b1;
        state_d         = StSat;
      end
      StSat: begin
        cmd_o.load_sat = 1'b1;
        state_d        = StMeter;
      end
      StMeter: begin
        // Commit only when the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/spgpm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel strip datapath
// Pan table lookup, gain products, rounding and saturation, block peak
// tracking and meter decay. Lane 0 is left (or mono), lane 1 is right.
// ----------------------------------------------------------------------------
module spgpm_dp #(
  parameter int SAMPLE_WIDTH    = spgpm_pkg::SampleWidthDef,
  parameter int PAN_TABLE_DEPTH = spgpm_pkg::PanTableDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire spgpm_pkg::cfg_t                cfg_i,
  input  wire spgpm_pkg::dp_cmd_t             cmd_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_left_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_right_i,
  input  wire logic                           block_end_i,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right_o,
  output logic [SAMPLE_WIDTH-2:0]             meter_left_o,
  output logic [SAMPLE_WIDTH-2:0]             meter_right_o
);
  import spgpm_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int MW   = SAMPLE_WIDTH - 1;
  localparam int IdxW = $clog2(PAN_TABLE_DEPTH);
  localparam int IpW  = IdxW + 17;
  localparam int GW   = 32;
  localparam int PW   = SAMPLE_WIDTH + GW;
  localparam int RW   = SAMPLE_WIDTH + 2;

  localparam logic [IdxW-1:0] IdxMax   = IdxW'(PAN_TABLE_DEPTH - 1);
  localparam logic [PW:0]     RoundBit = (PW + 1)'(1) << 30;
  localparam logic [RW-1:0]   PosMax   = RW'({MW{1'b1}});
  localparam logic [RW-1:0]   NegMax   = RW'(1) << (SAMPLE_WIDTH - 1);

  typedef logic [15:0] lut_t [PAN_TABLE_DEPTH];

  // Quarter-wave sine table, entry k = sin(pi/2 * k/(D-1)) in Q0.16.
  function automatic lut_t build_lut();
    lut_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    int          k;
    for (k = 0; k < PAN_TABLE_DEPTH; k++) begin
      x  = (64'(k) << 30) / 64'(PAN_TABLE_DEPTH - 1);
      x2 = (x * x) >> 30;
      p  = SinA7 - ((x2 * SinA9) >> 30);
      p  = SinA5 - ((x2 * p) >> 30);
      p  = SinA3 - ((x2 * p) >> 30);
      p  = SinA1 - ((x2 * p) >> 30);
      p  = (x * p) >> 30;
      p  = (p + 64'd8192) >> 14;
      t[k] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
    end
    return t;
  endfunction

  localparam lut_t PanLut = build_lut();

  logic            silent;
  logic            mono;

  // Item latched at acceptance.
  logic [SW-1:0]   mag_q [2];
  logic            neg_q [2];
  logic            last_q;

  // Step registers.
  logic [IdxW-1:0] idx_q, idx_d;
  logic [GW-1:0]   gain_q [2];
  logic [GW-1:0]   gain_d [2];
  logic [PW-1:0]   prod_q [2];
  logic [PW-1:0]   prod_d [2];
  logic [SW-1:0]   res_q  [2];
  logic [SW-1:0]   res_d  [2];
  logic [MW-1:0]   pk_q   [2];
  logic [MW-1:0]   pk_d   [2];

  // Meter state.
  logic [MW-1:0]   lvl_q [2];
  logic [MW-1:0]   lvl_d [2];
  logic [MW-1:0]   bpk_q [2];
  logic [MW-1:0]   bpk_d [2];

  // Output register.
  logic [SW-1:0]   out_l_q, out_r_q;
  logic [MW-1:0]   mtr_l_q, mtr_r_q;

  // Scratch values.
  logic [IpW-1:0]  idx_sum;
  logic [IdxW:0]   idx_raw;
  logic [SW-1:0]   samp [2];
  logic [PW:0]     rnd  [2];
  logic [RW-1:0]   rmag [2];
  logic [RW-1:0]   rsel [2];
  logic [RW-1:0]   rpk  [2];
  logic [MW+15:0]  dprod [2];
  logic [MW-1:0]   dec  [2];
  logic [MW-1:0]   npk  [2];
  logic [MW-1:0]   cand [2];

  assign silent = cfg_i.mute_enable | (cfg_i.other_soloed & ~cfg_i.solo_enable);
  assign mono   = cfg_i.mono_mode;
  assign samp[0] = sample_left_i;
  assign samp[1] = sample_right_i;

  // Capture the sample magnitudes and signs of an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < 2; i++) begin
        neg_q[i] <= samp[i][SW-1];
        mag_q[i] <= samp[i][SW-1] ? SW'(~samp[i] + 1'b1) : samp[i];
      end
      last_q <= block_end_i;
    end
  end

  // Pan index: ((pan + 1) scaled to the table) rounded, then clamped.
  always_comb begin
    idx_sum = IpW'(cfg_i.pan_position ^ 16'h8000) * IpW'(IdxMax) + IpW'(32768);
    idx_raw = idx_sum[IpW-1:16];
    idx_d   = (idx_raw > (IdxW + 1)'(IdxMax)) ? IdxMax : idx_raw[IdxW-1:0];
  end

  // Gains: volume times the cosine or sine entry; mono uses volume alone,
  // moved up 16 bits so the common shift by 31 becomes a shift by 15.
  always_comb begin
    gain_d[1] = GW'(cfg_i.volume_gain) * GW'(PanLut[idx_q]);
    if (mono) begin
      gain_d[0] = {cfg_i.volume_gain, 16'h0000};
    end else begin
      gain_d[0] = GW'(cfg_i.volume_gain) * GW'(PanLut[IdxMax - idx_q]);
    end
  end

  // Magnitude products.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_d[i] = PW'(mag_q[i]) * PW'(gain_q[i]);
    end
  end

  // Round half away from zero, saturate, restore the sign, take the peak.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rnd[i]  = {1'b0, prod_q[i]} + RoundBit;
      rmag[i] = rnd[i][PW:31];
      if (neg_q[i]) begin
        rsel[i]  = (rmag[i] > NegMax) ? NegMax : rmag[i];
        res_d[i] = SW'(~rsel[i][SW-1:0] + 1'b1);
      end else begin
        rsel[i]  = (rmag[i] > PosMax) ? PosMax : rmag[i];
        res_d[i] = rsel[i][SW-1:0];
      end
      rpk[i]  = (rmag[i] > PosMax) ? PosMax : rmag[i];
      pk_d[i] = rpk[i][MW-1:0];
      if (silent || (mono && (i == 1))) begin
        res_d[i] = '0;
        pk_d[i]  = '0;
      end
    end
  end

  // Step registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) begin
      idx_q <= idx_d;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.load_gain) begin
        gain_q[i] <= gain_d[i];
      end
      if (cmd_i.load_prod) begin
        prod_q[i] <= prod_d[i];
      end
      if (cmd_i.load_sat) begin
        res_q[i] <= res_d[i];
        pk_q[i]  <= pk_d[i];
      end
    end
  end

  // Block peaks and meter levels for the committing transaction.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dprod[i] = (MW + 16)'(lvl_q[i]) * (MW + 16)'(cfg_i.decay_factor);
      dec[i]   = dprod[i][MW+15:16];
      npk[i]   = (pk_q[i] > bpk_q[i]) ? pk_q[i] : bpk_q[i];
      cand[i]  = (npk[i] > lvl_q[i]) ? npk[i] : dec[i];
      lvl_d[i] = lvl_q[i];
      bpk_d[i] = npk[i];
    end
    if (last_q) begin
      if (silent) begin
        lvl_d[0] = dec[0];
        lvl_d[1] = dec[1];
      end else if (mono) begin
        lvl_d[0] = cand[0];
        lvl_d[1] = cand[0];
      end else begin
        lvl_d[0] = cand[0];
        lvl_d[1] = cand[1];
      end
      bpk_d[0] = '0;
      bpk_d[1] = '0;
    end
  end

  // Meter state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        lvl_q[i] <= '0;
        bpk_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < 2; i++) begin
        lvl_q[i] <= lvl_d[i];
        bpk_q[i] <= bpk_d[i];
      end
    end
  end

  // Output register, loaded when a result commits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_l_q <= res_q[0];
      out_r_q <= res_q[1];
      mtr_l_q <= lvl_d[0];
      mtr_r_q <= mono ? lvl_d[0] : lvl_d[1];
    end
  end

  assign out_left_o    = out_l_q;
  assign out_right_o   = out_r_q;
  assign meter_left_o  = mtr_l_q;
  assign meter_right_o = mtr_r_q;

endmodule
`default_nettype wire

/* sim/tb_stereo_pan_gain_peak_meter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the stereo pan, gain and peak meter channel strip
// Sample pairs are sent through the input handshake, and every accepted
// transaction is run through a bit-accurate predictor of the strip. Each
// result transaction is checked field by field against the oldest
// prediction. A short directed part covers the sample extremes, the pan and
// volume extremes, the mono, mute and solo modes, and a mode change in the
// middle of a block. Random phases with random settings follow, with random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_stereo_pan_gain_peak_meter_core;
  import spgpm_pkg::*;

  localparam int SW       = SampleWidthDef;
  localparam int PanDepth = PanTableDepthDef;
  localparam int DrainPad = 8;
  localparam int HoldOffCycles = 400;
  localparam int RandPhases    = 12;
  localparam int PhaseItems    = 128;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

  // Register defaults after reset.
  localparam logic [15:0] VolumeUnity  = 16'd32768;
  localparam logic [15:0] DecayDefault = 16'd62259;

  // Q30 coefficients of the odd sine polynomial used to fill the pan table.
  localparam logic [63:0] SinC1 = 64'd1686629713;
  localparam logic [63:0] SinC3 = 64'd693598671;
  localparam logic [63:0] SinC5 = 64'd85569306;
  localparam logic [63:0] SinC7 = 64'd5026995;
  localparam logic [63:0] SinC9 = 64'd172270;

  localparam logic [SW-1:0] SampleMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SampleMin = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    logic          last;
  } sample_pair_t;

  typedef struct packed {
    logic [SW-1:0] out_left;
    logic [SW-1:0] out_right;
    logic [SW-2:0] meter_left;
    logic [SW-2:0] meter_right;
  } strip_result_t;

  // Clock, reset and block ports.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [SW-1:0]       sample_left_i  = '0;
  logic [SW-1:0]       sample_right_i = '0;
  logic                block_end_i    = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [SW-1:0]       out_left_o;
  logic [SW-1:0]       out_right_o;
  logic [SW-2:0]       meter_left_o;
  logic [SW-2:0]       meter_right_o;

  // Stimulus and checking bookkeeping.
  sample_pair_t  pending_pairs[$];
  strip_result_t expected_strip[$];
  logic          pair_taken = 1'b0;
  int            error_count = 0;
  int            send_idle_pct = 20;
  int            recv_idle_pct = 20;
  int            hold_requests = 0;
  int            hold_served   = 0;
  int            hold_left     = 0;

  // Predictor copy of the configuration and the meter state.
  logic [15:0]   cfg_volume;
  logic [15:0]   cfg_pan;
  logic          cfg_mute;
  logic          cfg_solo;
  logic          cfg_other_solo;
  logic [15:0]   cfg_decay;
  logic          cfg_mono;
  logic [SW-2:0] peak_l;
  logic [SW-2:0] peak_r;
  logic [SW-2:0] level_l;
  logic [SW-2:0] level_r;
  logic [15:0]   sine_tab [PanDepth];

  stereo_pan_gain_peak_meter_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .block_end_i    (block_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .meter_left_o   (meter_left_o),
    .meter_right_o  (meter_right_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Quarter-wave sine entry k of the pan table, unsigned Q0.16.
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0] x, x2, p;
    x  = (64'(k) << 30) / 64'(PanDepth - 1);
    x2 = (x * x) >> 30;
    p  = SinC7 - ((x2 * SinC9) >> 30);
    p  = SinC5 - ((x2 * p) >> 30);
    p  = SinC3 - ((x2 * p) >> 30);
    p  = SinC1 - ((x2 * p) >> 30);
    p  = (x * p) >> 30;
    p  = (p + 64'd8192) >> 14;
    if (p > 64'd65535) p = 64'd65535;
    return p[15:0];
  endfunction

  // Scale a signed sample by an unsigned gain, round half away from zero
  // and saturate to the sample range.
  function automatic logic [SW-1:0] scale_sat(input logic [SW-1:0] s,
                                              input logic [63:0] g,
                                              input int unsigned shift);
    logic [63:0] mag, r;
    mag = s[SW-1] ? 64'd0 - {{(64-SW){1'b1}}, s} : {{(64-SW){1'b0}}, s};
    r   = (mag * g + (64'd1 << (shift - 1))) >> shift;
    if (s[SW-1]) begin
      if (r > (64'd1 << (SW - 1))) r = 64'd1 << (SW - 1);
      r = 64'd0 - r;
    end else if (r > 64'(SampleMax)) begin
      r = 64'(SampleMax);
    end
    return r[SW-1:0];
  endfunction

  // Magnitude of an output sample, capped at the largest positive value.
  function automatic logic [SW-2:0] abs_cap(input logic [SW-1:0] v);
    logic [SW-1:0] mag;
    mag = v[SW-1] ? -v : v;
    return mag[SW-1] ? SampleMax[SW-2:0] : mag[SW-2:0];
  endfunction

  function automatic logic [SW-2:0] decay_level(input logic [SW-2:0] lvl);
    logic [63:0] t;
    t = (64'(lvl) * 64'(cfg_decay)) >> 16;
    return t[SW-2:0];
  endfunction

  // Expected result of one sample pair; advances the peaks and meters.
  function automatic strip_result_t predict_channel_strip(input logic [SW-1:0] sl,
                                                          input logic [SW-1:0] sr,
                                                          input logic last);
    strip_result_t r;
    logic          silent;
    logic [63:0]   u, idx;
    logic [SW-2:0] pk_l, pk_r;
    r = '0;
    silent = cfg_mute || (cfg_other_solo && !cfg_solo);
    if (silent) begin
      if (last) begin
        level_l = decay_level(level_l);
        level_r = decay_level(level_r);
      end
    end else if (cfg_mono) begin
      r.out_left = scale_sat(sl, 64'(cfg_volume), 15);
      pk_l = abs_cap(r.out_left);
      if (pk_l > peak_l) peak_l = pk_l;
      if (last) begin
        level_l = (peak_l > level_l) ? peak_l : decay_level(level_l);
        level_r = level_l;
      end
    end else begin
      // Pan index into the table; the left gain reads it mirrored.
      u   = 64'(cfg_pan ^ 16'h8000);
      idx = (u * 64'(PanDepth - 1) + 64'd32768) >> 16;
      if (idx > 64'(PanDepth - 1)) idx = 64'(PanDepth - 1);
      r.out_left  = scale_sat(sl, 64'(cfg_volume) * 64'(sine_tab[PanDepth - 1 - idx]), 31);
      r.out_right = scale_sat(sr, 64'(cfg_volume) * 64'(sine_tab[idx]), 31);
      pk_l = abs_cap(r.out_left);
      pk_r = abs_cap(r.out_right);
      if (pk_l > peak_l) peak_l = pk_l;
      if (pk_r > peak_r) peak_r = pk_r;
      if (last) begin
        level_l = (peak_l > level_l) ? peak_l : decay_level(level_l);
        level_r = (peak_r > level_r) ? peak_r : decay_level(level_r);
      end
    end
    if (last) begin
      peak_l = '0;
      peak_r = '0;
    end
    r.meter_left  = level_l;
    r.meter_right = cfg_mono ? level_l : level_r;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Register write through the configuration port, mirrored in the predictor.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegVolume:      cfg_volume     = data;
      RegPan:         cfg_pan        = data;
      RegMute:        cfg_mute       = data[0];
      RegSolo:        cfg_solo       = data[0];
      RegOtherSoloed: cfg_other_solo = data[0];
      RegDecay:       cfg_decay      = data;
      RegMono:        cfg_mono       = data[0];
      default: ;
    endcase
  endtask

  task automatic push_pair(input logic [SW-1:0] sl, input logic [SW-1:0] sr,
                           input logic last);
    sample_pair_t p;
    p.left  = sl;
    p.right = sr;
    p.last  = last;
    pending_pairs.push_back(p);
  endtask

  // Wait until every queued pair is sent and every result has come back.
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid_i || expected_strip.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainPad) @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] s;
    case ($urandom_range(9))
      0:       s = SampleMax;
      1:       s = SampleMin;
      2:       s = '0;
      3:       s = {{(SW-12){$urandom_range(1) == 1}}, 12'($urandom)};
      default: s = SW'($urandom);
    endcase
    return s;
  endfunction

  // Random value for a one-bit register, with noise in the unused bits.
  function automatic logic [15:0] flag_word(input logic bit_val);
    logic [15:0] w;
    w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
    w[0] = bit_val;
    return w;
  endfunction

  task automatic set_random_mix();
    logic [15:0] v;
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(4))
        0:       v = 16'd0;
        1:       v = 16'hFFFF;
        2:       v = VolumeUnity;
        default: v = 16'($urandom);
      endcase
      write_reg(RegVolume, v);
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(4))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = 16'h0000;
        default: v = 16'($urandom);
      endcase
      write_reg(RegPan, v);
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(3))
        0:       v = 16'd0;
        1:       v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      write_reg(RegDecay, v);
    end
    write_reg(RegMute, flag_word($urandom_range(5) == 0));
    if ($urandom_range(1) == 0) write_reg(RegSolo, flag_word($urandom_range(1) == 1));
    if ($urandom_range(1) == 0) write_reg(RegOtherSoloed, flag_word($urandom_range(2) == 0));
    write_reg(RegMono, flag_word($urandom_range(3) == 0));
    if ($urandom_range(3) == 0) write_reg(RegUnused, 16'($urandom));
  endtask

  // Mostly well-formed blocks of random length; now and then a block with
  // block_end scattered at random.
  task automatic queue_random_blocks(input int count);
    int  remaining, len, k;
    logic scattered;
    remaining = count;
    while (remaining > 0) begin
      len = $urandom_range(1, 16);
      scattered = ($urandom_range(9) == 0);
      for (k = 0; k < len && remaining > 0; k++) begin
        push_pair(rand_sample(), rand_sample(),
                  scattered ? ($urandom_range(1) == 1) : (k == len - 1));
        remaining--;
      end
    end
  endtask

  // Input side: offers the next pair once the current transaction is taken.
  always @(negedge clk_i) begin : driver
    sample_pair_t nxt;
    if (rst_ni && (!in_valid_i || pair_taken)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_pairs.pop_front();
        in_valid_i     <= 1'b1;
        sample_left_i  <= nxt.left;
        sample_right_i <= nxt.right;
        block_end_i    <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Record each accepted input transaction and predict its result.
  always @(posedge clk_i) begin
    pair_taken = rst_ni && in_valid_i && in_ready_o;
    if (pair_taken) begin
      expected_strip.push_back(predict_channel_strip(sample_left_i, sample_right_i,
                                                     block_end_i));
    end
  end

  // Output side: random ready, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HoldOffCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin : monitor
    strip_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_strip.size() == 0) begin
        report_mismatch("unexpected result, out_left", 32'(out_left_o), 32'd0);
      end else begin
        want = expected_strip.pop_front();
        if (out_left_o !== want.out_left)
          report_mismatch("out_left", 32'(out_left_o), 32'(want.out_left));
        if (out_right_o !== want.out_right)
          report_mismatch("out_right", 32'(out_right_o), 32'(want.out_right));
        if (meter_left_o !== want.meter_left)
          report_mismatch("meter_left", 32'(meter_left_o), 32'(want.meter_left));
        if (meter_right_o !== want.meter_right)
          report_mismatch("meter_right", 32'(meter_right_o), 32'(want.meter_right));
      end
    end
  end

  // Main sequence: reset, directed phases, then random phases.
  initial begin : stimulus
    int k;
    for (k = 0; k < PanDepth; k++) sine_tab[k] = sine_entry(k);
    cfg_volume     = VolumeUnity;
    cfg_pan        = 16'd0;
    cfg_mute       = 1'b0;
    cfg_solo       = 1'b0;
    cfg_other_solo = 1'b0;
    cfg_decay      = DecayDefault;
    cfg_mono       = 1'b0;
    peak_l  = '0;
    peak_r  = '0;
    level_l = '0;
    level_r = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults with the sample extremes.
    push_pair(SampleMax, SampleMin, 1'b0);
    push_pair(SampleMin, SampleMax, 1'b0);
    push_pair('0, '0, 1'b0);
    push_pair('1, SW'(1), 1'b0);
    push_pair(SW'(1), '1, 1'b1);
    wait_drained();

    // Full volume, hard left: saturation on both signs.
    write_reg(RegVolume, 16'hFFFF);
    write_reg(RegPan, 16'h8000);
    push_pair(SampleMax, SampleMax, 1'b0);
    push_pair(SampleMin, SampleMin, 1'b1);
    wait_drained();

    // Hard right with a decay factor of zero; the block is left open on purpose.
    write_reg(RegPan, 16'h7FFF);
    write_reg(RegDecay, 16'd0);
    push_pair(SampleMin, SampleMax, 1'b1);
    push_pair(SW'(12345), -SW'(54321), 1'b0);
    wait_drained();

    // Switch to mono in the middle of the block; the peak so far is kept.
    write_reg(RegMono, 16'd1);
    write_reg(RegVolume, VolumeUnity);
    write_reg(RegDecay, 16'hFFFF);
    push_pair(SampleMin, SampleMax, 1'b0);
    push_pair(SampleMax, SW'(7), 1'b1);
    wait_drained();

    // Muted: outputs are zero and the meters only decay.
    write_reg(RegMute, 16'd1);
    write_reg(RegDecay, 16'd40000);
    write_reg(RegUnused, 16'hFFFF);
    push_pair(SampleMax, SampleMax, 1'b0);
    push_pair(SampleMax, SampleMin, 1'b1);
    wait_drained();

    // Another track soloed, then this one soloed too, then zero volume.
    write_reg(RegMute, 16'd0);
    write_reg(RegMono, 16'd0);
    write_reg(RegOtherSoloed, 16'd1);
    push_pair(SW'(100), SW'(100), 1'b1);
    wait_drained();
    write_reg(RegSolo, 16'd1);
    push_pair(SampleMax, SampleMin, 1'b1);
    wait_drained();
    write_reg(RegVolume, 16'd0);
    push_pair(SampleMin, SampleMin, 1'b1);
    wait_drained();

    // Random phases; one without idling and one with a long output stall.
    for (k = 0; k < RandPhases; k++) begin
      set_random_mix();
      send_idle_pct = (k == 3) ? 0 : 20;
      recv_idle_pct = (k == 3) ? 0 : 20;
      if (k == 6) hold_requests++;
      queue_random_blocks(PhaseItems);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb_stereo_pan_gain_peak_meter_core: done, clean");
    end else begin
      $display("tb_stereo_pan_gain_peak_meter_core: done, errors");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4000000;
    $display("tb_stereo_pan_gain_peak_meter_core: done, errors");
    $finish;
  end

endmodule
